FILE: rtl/core/hsv_to_rgbw_pwm_compare_assert.svh
// ---------------------------------------------------------------------------
// HSV to RGBW PWM compare: assertion macros
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGBW_PWM_COMPARE_ASSERT_SVH
`define HSV_TO_RGBW_PWM_COMPARE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define HSVPWM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsvpwm: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define HSVPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsvpwm: next-cycle check failed");
`else
`define HSVPWM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HSVPWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/hsvpwm_pkg.sv
// ---------------------------------------------------------------------------
// HSV to RGBW PWM compare: shared package
// Pipeline depths, scale constants, reciprocals and register indexes.
// ---------------------------------------------------------------------------
package hsvpwm_pkg;

  // Pipeline depth: color conversion stages, then duty and compare stages
  localparam int COLOR_STAGES = 10;
  localparam int DUTY_STAGES  = 7;
  localparam int NSTAGES      = COLOR_STAGES + DUTY_STAGES;

  // Scale constants
  localparam logic [8:0] HUE_TURN    = 9'd360;
  localparam logic [5:0] SECTOR_SPAN = 6'd60;
  localparam logic [7:0] LEVEL_MAX   = 8'd255;
  localparam logic [9:0] SCALE_MAX   = 10'd1000;
  localparam logic [4:0] GEAR_MAX    = 5'd20;

  // Floor reciprocals: each estimate is the true quotient or one less
  localparam logic [15:0] RECIP_360    = 16'd46603;    // 2^24 / 360
  localparam logic [18:0] RECIP_1000_S = 19'd268435;   // 2^28 / 1000
  localparam logic [14:0] RECIP_60     = 15'd17476;    // 2^20 / 60
  localparam logic [24:0] RECIP_255    = 25'd16843009; // 2^32 / 255
  localparam logic [26:0] RECIP_1000_W = 27'd68719476; // 2^36 / 1000
  localparam logic [21:0] RECIP_20     = 22'd3355443;  // 2^26 / 20

  // Configuration register indexes
  localparam logic [1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [1:0] CFG_PERIOD     = 2'd1;
  localparam logic [1:0] CFG_GEAR       = 2'd2;

  // Configuration reset values
  localparam logic [15:0] FULL_SCALE_RST = 16'd1000;
  localparam logic [15:0] PERIOD_RST     = 16'd1000;
  localparam logic [4:0]  GEAR_RST       = 5'd20;

endpackage

FILE: rtl/core/hsvpwm_if.sv
// ---------------------------------------------------------------------------
// HSV to RGBW PWM compare: stream interfaces
// Valid/ready channels for pixel input and PWM compare results.
// ---------------------------------------------------------------------------
interface hsvpwm_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [9:0]  saturation;
  logic [9:0]  brightness;
  logic [9:0]  white;

  modport source (output valid, hue, saturation, brightness, white, input ready);
  modport sink   (input valid, hue, saturation, brightness, white, output ready);
endinterface

interface hsvpwm_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  logic [7:0]  blue_level;
  logic [15:0] red_compare;
  logic [15:0] green_compare;
  logic [15:0] blue_compare;
  logic [15:0] white_compare;
  logic        compare_clipped;

  modport source (output valid, red_level, green_level, blue_level, red_compare,
                  green_compare, blue_compare, white_compare, compare_clipped,
                  input ready);
  modport sink   (input valid, red_level, green_level, blue_level, red_compare,
                  green_compare, blue_compare, white_compare, compare_clipped,
                  output ready);
endinterface

FILE: rtl/core/hsv_to_rgbw_pwm_compare.sv
// 17 register stages from pixel transfer to result valid; most are multiplies and fixes.
// Throughput: one pixel per cycle unless a stalled result fills every stage.
// A stalled result holds the last stage; earlier stages keep filling empty slots.
// Reset (rst, synchronous) clears all stage valid bits and loads full scale 1000,
// period 1000 and gear 20.
// ---------------------------------------------------------------------------
// HSV to RGBW PWM compare: top level
// Converts HSV plus white to RGB levels and four PWM timer compare values.
// ---------------------------------------------------------------------------
`include "hsv_to_rgbw_pwm_compare_assert.svh"

module hsv_to_rgbw_pwm_compare (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  hsvpwm_pixel_if.sink           pixel,
  hsvpwm_result_if.source        result
);

  localparam int NS = hsvpwm_pkg::NSTAGES;
  localparam int NC = hsvpwm_pkg::COLOR_STAGES;
  localparam int ND = hsvpwm_pkg::DUTY_STAGES;
  localparam logic [NS-1:0] ONE_V = NS'(1);

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [3:0][25:0]  x;
    logic [3:0][15:0]  base;
    logic [3:0][20:0]  gp;
    logic [3:0][15:0]  duty;
    logic [3:0][15:0]  cmp;
    logic              clip;
  } dpipe_t;

  logic [15:0] full_scale_count;
  logic [15:0] pwm_period;
  logic [4:0]  brightness_gear;
  logic [4:0]  gear_c;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic [7:0] c_red, c_green, c_blue;
  logic [9:0] c_white;

  dpipe_t dp  [ND];
  dpipe_t nxd [ND];

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_count <= hsvpwm_pkg::FULL_SCALE_RST;
      pwm_period       <= hsvpwm_pkg::PERIOD_RST;
      brightness_gear  <= hsvpwm_pkg::GEAR_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        hsvpwm_pkg::CFG_FULL_SCALE: full_scale_count <= cfg_data;
        hsvpwm_pkg::CFG_PERIOD:     pwm_period       <= cfg_data;
        hsvpwm_pkg::CFG_GEAR:       brightness_gear  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign gear_c = (brightness_gear > hsvpwm_pkg::GEAR_MAX) ? hsvpwm_pkg::GEAR_MAX
                                                           : brightness_gear;

  // Stage k may load when the result is taken or some slot at or after k is empty
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = result.ready | ~(&(v | ((ONE_V << k) - ONE_V)));
    end
  end

  assign pixel.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  hsvpwm_color u_color (
    .clk        (clk),
    .en         (en[NC-1:0]),
    .hue        (pixel.hue),
    .saturation (pixel.saturation),
    .brightness (pixel.brightness),
    .white      (pixel.white),
    .red        (c_red),
    .green      (c_green),
    .blue       (c_blue),
    .white_lvl  (c_white)
  );

  // Duty and compare stages; lanes 0..2 are red, green, blue, lane 3 is white
  always_comb begin
    logic [48:0] pc;
    logic [52:0] pw;
    logic [23:0] rem24;
    logic [25:0] rem26;
    logic [42:0] pd;
    logic [20:0] rem21;

    // Stage 0: level times full scale
    nxd[0]       = '0;
    nxd[0].red   = c_red;
    nxd[0].green = c_green;
    nxd[0].blue  = c_blue;
    nxd[0].x[0]  = 26'(c_red)   * 26'(full_scale_count);
    nxd[0].x[1]  = 26'(c_green) * 26'(full_scale_count);
    nxd[0].x[2]  = 26'(c_blue)  * 26'(full_scale_count);
    nxd[0].x[3]  = 26'(c_white) * 26'(full_scale_count);

    // Stage 1: base estimate, over 255 for colors and over 1000 for white
    nxd[1] = dp[0];
    for (int i = 0; i < 3; i++) begin
      pc             = 49'(dp[0].x[i][23:0]) * 49'(hsvpwm_pkg::RECIP_255);
      nxd[1].base[i] = pc[47:32];
    end
    pw             = 53'(dp[0].x[3]) * 53'(hsvpwm_pkg::RECIP_1000_W);
    nxd[1].base[3] = pw[51:36];

    // Stage 2: base fix
    nxd[2] = dp[1];
    for (int i = 0; i < 3; i++) begin
      rem24 = dp[1].x[i][23:0] - 24'(dp[1].base[i]) * 24'(hsvpwm_pkg::LEVEL_MAX);
      if (rem24 >= 24'(hsvpwm_pkg::LEVEL_MAX)) begin
        nxd[2].base[i] = dp[1].base[i] + 16'd1;
      end
    end
    rem26 = dp[1].x[3] - 26'(dp[1].base[3]) * 26'(hsvpwm_pkg::SCALE_MAX);
    if (rem26 >= 26'(hsvpwm_pkg::SCALE_MAX)) begin
      nxd[2].base[3] = dp[1].base[3] + 16'd1;
    end

    // Stage 3: base times gear
    nxd[3] = dp[2];
    for (int i = 0; i < 4; i++) begin
      nxd[3].gp[i] = 21'(dp[2].base[i]) * 21'(gear_c);
    end

    // Stage 4: duty estimate over 20
    nxd[4] = dp[3];
    for (int i = 0; i < 4; i++) begin
      pd             = 43'(dp[3].gp[i]) * 43'(hsvpwm_pkg::RECIP_20);
      nxd[4].duty[i] = pd[41:26];
    end

    // Stage 5: duty fix
    nxd[5] = dp[4];
    for (int i = 0; i < 4; i++) begin
      rem21 = dp[4].gp[i] - 21'(dp[4].duty[i]) * 21'(hsvpwm_pkg::GEAR_MAX);
      if (rem21 >= 21'(hsvpwm_pkg::GEAR_MAX)) begin
        nxd[5].duty[i] = dp[4].duty[i] + 16'd1;
      end
    end

    // Stage 6: period minus duty, clip at zero and flag
    nxd[6]      = dp[5];
    nxd[6].clip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (dp[5].duty[i] > pwm_period) begin
        nxd[6].cmp[i] = '0;
        nxd[6].clip   = 1'b1;
      end else begin
        nxd[6].cmp[i] = pwm_period - dp[5].duty[i];
      end
    end
  end

  // Advance duty stages with their enables
  always_ff @(posedge clk) begin
    for (int j = 0; j < ND; j++) begin
      if (en[NC+j]) begin
        dp[j] <= nxd[j];
      end
    end
  end

  // Last stage is the output register
  assign result.valid           = v[NS-1];
  assign result.red_level       = dp[ND-1].red;
  assign result.green_level     = dp[ND-1].green;
  assign result.blue_level      = dp[ND-1].blue;
  assign result.red_compare     = dp[ND-1].cmp[0];
  assign result.green_compare   = dp[ND-1].cmp[1];
  assign result.blue_compare    = dp[ND-1].cmp[2];
  assign result.white_compare   = dp[ND-1].cmp[3];
  assign result.compare_clipped = dp[ND-1].clip;

  // A transfer always lands in the first stage
  `HSVPWM_ASSERT_NEXT(a_accept_loads, clk, rst, pixel.valid && pixel.ready, v[0])
  // Compare values never exceed the period
  `HSVPWM_ASSERT_IMPLIES(a_cmp_bounded, clk, rst, result.valid,
    (result.red_compare <= pwm_period) && (result.green_compare <= pwm_period) &&
    (result.blue_compare <= pwm_period) && (result.white_compare <= pwm_period))
  // Duty cannot pass full scale, so no clipping when period covers it
  `HSVPWM_ASSERT_IMPLIES(a_no_clip, clk, rst,
    result.valid && (pwm_period >= full_scale_count), !result.compare_clipped)
  // Gear zero gives zero duty; checked here on the red and white channels
  `HSVPWM_ASSERT_IMPLIES(a_gear_off, clk, rst, result.valid && (brightness_gear == 5'd0),
    (result.red_compare == pwm_period) && (result.white_compare == pwm_period) &&
    !result.compare_clipped)

endmodule

FILE: rtl/core/hsvpwm_color.sv
// ---------------------------------------------------------------------------
// HSV to RGBW PWM compare: color conversion pipeline
// Ten-stage integer six-sector HSV to 8-bit RGB, advanced by per-stage enables.
// ---------------------------------------------------------------------------
module hsvpwm_color (
  input  logic                                clk,
  input  logic [hsvpwm_pkg::COLOR_STAGES-1:0] en,
  input  logic [15:0]                         hue,
  input  logic [9:0]                          saturation,
  input  logic [9:0]                          brightness,
  input  logic [9:0]                          white,
  output logic [7:0]                          red,
  output logic [7:0]                          green,
  output logic [7:0]                          blue,
  output logic [9:0]                          white_lvl
);

  localparam int NC = hsvpwm_pkg::COLOR_STAGES;

  typedef enum logic [2:0] {
    SEC_RED_YEL, SEC_YEL_GRN, SEC_GRN_CYN, SEC_CYN_BLU, SEC_BLU_MAG, SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  hq;
    logic [8:0]  h;
    logic [9:0]  sat;
    logic [17:0] vt;
    logic [7:0]  top;
    sector_t     sector;
    logic [5:0]  hm;
    logic [17:0] bp;
    logic [7:0]  bottom;
    logic [13:0] rp;
    logic [7:0]  ramp;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  white;
  } cpipe_t;

  cpipe_t st [NC];
  cpipe_t nx [NC];

  // Per-stage work; each stage starts from the one before it
  always_comb begin
    logic [9:0]  v;
    logic [31:0] p32;
    logic [16:0] hrem;
    logic [36:0] p37;
    logic [17:0] rem18;
    logic [8:0]  sbase;
    logic [28:0] p29;
    logic [13:0] rem14;

    // Stage 0: clamp inputs, hue quotient estimate, value times 255
    nx[0]       = '0;
    nx[0].hue   = hue;
    nx[0].sat   = (saturation > hsvpwm_pkg::SCALE_MAX) ? hsvpwm_pkg::SCALE_MAX : saturation;
    v           = (brightness > hsvpwm_pkg::SCALE_MAX) ? hsvpwm_pkg::SCALE_MAX : brightness;
    nx[0].white = (white > hsvpwm_pkg::SCALE_MAX) ? hsvpwm_pkg::SCALE_MAX : white;
    p32         = 32'(hue) * 32'(hsvpwm_pkg::RECIP_360);
    nx[0].hq    = p32[31:24];
    nx[0].vt    = 18'(v) * 18'(hsvpwm_pkg::LEVEL_MAX);

    // Stage 1: hue remainder fix, top estimate
    nx[1]   = st[0];
    hrem    = 17'(st[0].hue) - 17'(st[0].hq) * 17'(hsvpwm_pkg::HUE_TURN);
    nx[1].h = (hrem >= 17'(hsvpwm_pkg::HUE_TURN)) ?
              9'(hrem - 17'(hsvpwm_pkg::HUE_TURN)) : 9'(hrem);
    p37       = 37'(st[0].vt) * 37'(hsvpwm_pkg::RECIP_1000_S);
    nx[1].top = p37[35:28];

    // Stage 2: top fix, sector and offset within sector
    nx[2] = st[1];
    rem18 = st[1].vt - 18'(st[1].top) * 18'(hsvpwm_pkg::SCALE_MAX);
    if (rem18 >= 18'(hsvpwm_pkg::SCALE_MAX)) begin
      nx[2].top = st[1].top + 8'd1;
    end
    priority if (st[1].h < 9'd60) begin
      nx[2].sector = SEC_RED_YEL;
      sbase        = 9'd0;
    end else if (st[1].h < 9'd120) begin
      nx[2].sector = SEC_YEL_GRN;
      sbase        = 9'd60;
    end else if (st[1].h < 9'd180) begin
      nx[2].sector = SEC_GRN_CYN;
      sbase        = 9'd120;
    end else if (st[1].h < 9'd240) begin
      nx[2].sector = SEC_CYN_BLU;
      sbase        = 9'd180;
    end else if (st[1].h < 9'd300) begin
      nx[2].sector = SEC_BLU_MAG;
      sbase        = 9'd240;
    end else begin
      nx[2].sector = SEC_MAG_RED;
      sbase        = 9'd300;
    end
    nx[2].hm = 6'(st[1].h - sbase);

    // Stage 3: bottom product
    nx[3]    = st[2];
    nx[3].bp = 18'(st[2].top) * 18'(hsvpwm_pkg::SCALE_MAX - st[2].sat);

    // Stage 4: bottom estimate
    nx[4]        = st[3];
    p37          = 37'(st[3].bp) * 37'(hsvpwm_pkg::RECIP_1000_S);
    nx[4].bottom = p37[35:28];

    // Stage 5: bottom fix
    nx[5] = st[4];
    rem18 = st[4].bp - 18'(st[4].bottom) * 18'(hsvpwm_pkg::SCALE_MAX);
    if (rem18 >= 18'(hsvpwm_pkg::SCALE_MAX)) begin
      nx[5].bottom = st[4].bottom + 8'd1;
    end

    // Stage 6: ramp product
    nx[6]    = st[5];
    nx[6].rp = 14'(st[5].top - st[5].bottom) * 14'(st[5].hm);

    // Stage 7: ramp estimate
    nx[7]      = st[6];
    p29        = 29'(st[6].rp) * 29'(hsvpwm_pkg::RECIP_60);
    nx[7].ramp = p29[27:20];

    // Stage 8: ramp fix
    nx[8] = st[7];
    rem14 = st[7].rp - 14'(st[7].ramp) * 14'(hsvpwm_pkg::SECTOR_SPAN);
    if (rem14 >= 14'(hsvpwm_pkg::SECTOR_SPAN)) begin
      nx[8].ramp = st[7].ramp + 8'd1;
    end

    // Stage 9: pick channel levels by sector
    nx[9] = st[8];
    unique case (st[8].sector)
      SEC_RED_YEL: begin
        nx[9].red   = st[8].top;
        nx[9].green = st[8].bottom + st[8].ramp;
        nx[9].blue  = st[8].bottom;
      end
      SEC_YEL_GRN: begin
        nx[9].red   = st[8].top - st[8].ramp;
        nx[9].green = st[8].top;
        nx[9].blue  = st[8].bottom;
      end
      SEC_GRN_CYN: begin
        nx[9].red   = st[8].bottom;
        nx[9].green = st[8].top;
        nx[9].blue  = st[8].bottom + st[8].ramp;
      end
      SEC_CYN_BLU: begin
        nx[9].red   = st[8].bottom;
        nx[9].green = st[8].top - st[8].ramp;
        nx[9].blue  = st[8].top;
      end
      SEC_BLU_MAG: begin
        nx[9].red   = st[8].bottom + st[8].ramp;
        nx[9].green = st[8].bottom;
        nx[9].blue  = st[8].top;
      end
      default: begin
        nx[9].red   = st[8].top;
        nx[9].green = st[8].bottom;
        nx[9].blue  = st[8].top - st[8].ramp;
      end
    endcase
  end

  // Advance each stage when its enable is set
  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      if (en[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  assign red       = st[NC-1].red;
  assign green     = st[NC-1].green;
  assign blue      = st[NC-1].blue;
  assign white_lvl = st[NC-1].white;

endmodule
